@@ src/cfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Command frame parser package
// Types and constants shared by the frame parser and the reply serialiser.
// ----------------------------------------------------------------------------
package cfpr_pkg;

  localparam logic [7:0] SofByte  = 8'hEF;
  localparam logic [7:0] EofByte  = 8'hFE;
  localparam logic [7:0] DoneCmd  = 8'h17;
  localparam logic [7:0] DoneData = 8'h00;

  localparam int unsigned ReplyLen = 5;
  localparam int unsigned CntW     = $clog2(ReplyLen);
  localparam logic [CntW-1:0] LastIdx = CntW'(ReplyLen - 1);

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CODE = 3'd0,
    CFG_STOP_CODE  = 3'd1,
    CFG_PAUSE_CODE = 3'd2,
    CFG_RAISE_CODE = 3'd3,
    CFG_LOWER_CODE = 3'd4,
    CFG_NAK_VALUE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MSG_NONE  = 3'd0,
    MSG_GO    = 3'd1,
    MSG_HALT  = 3'd2,
    MSG_HOLD  = 3'd3,
    MSG_RAISE = 3'd4,
    MSG_LOWER = 3'd5
  } msg_type_e;

  typedef enum logic [4:0] {
    POS_HUNT = 5'b00001,
    POS_CMD  = 5'b00010,
    POS_DATA = 5'b00100,
    POS_CHK  = 5'b01000,
    POS_END  = 5'b10000
  } frame_pos_e;

  typedef struct packed {
    logic [ReplyLen-1:0][7:0] bytes;
    msg_type_e                msg_type;
    logic [7:0]               data_byte;
    logic                     refused;
    logic                     from_frame;
  } reply_t;

endpackage

@@ src/cfpr_if.sv @@
// ----------------------------------------------------------------------------
// Command frame parser channels
// Valid/ready channels for received bytes and for reply bytes.
// ----------------------------------------------------------------------------
interface cfpr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       busy_req;

  modport source (output valid, kind, rx_byte, busy_req, input ready);
  modport sink   (input valid, kind, rx_byte, busy_req, output ready);
endinterface

interface cfpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [2:0] msg_type;
  logic [7:0] data_byte;
  logic       refused;
  logic       from_frame;

  modport source (output valid, tx_byte, last_byte, msg_type, data_byte, refused,
                  from_frame, input ready);
  modport sink   (input valid, tx_byte, last_byte, msg_type, data_byte, refused,
                  from_frame, output ready);
endinterface

@@ src/command_frame_parser_responder_unit.sv @@
// ----------------------------------------------------------------------------
// Command frame parser and responder
// Parses five-byte command frames from a byte stream and sends five-byte replies.
//
// Items enter on in_ch: a received byte (kind 0) or a request to send the
// completed frame (kind 1). Every byte is parsed in the cycle it is accepted.
// A good frame, or a completed-frame request, yields a reply of five items on
// out_ch, one byte per item with last_byte set on the fifth.
// The first reply item is offered only after the item that completes it has
// passed through the pending reply register and then the output serialiser.
// Input items are taken every cycle while the pending register is free; with
// one reply per five-byte frame and no receiver stall the stream runs at one
// byte per cycle, while back-to-back completed-frame requests are held off
// while the pending register waits for the serialiser to finish a reply.
// When the receiver stalls, the current reply byte is held and, once a second
// reply is pending, in_ch.ready drops until the serialiser frees the register.
// Reset returns the parser to hunting for a start byte, empties both reply
// registers and loads the default command codes and NAK byte.
// ----------------------------------------------------------------------------
module command_frame_parser_responder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cfpr_pkg::CfgDataW-1:0] cfg_wdata_i,
  cfpr_in_if.sink                       in_ch,
  cfpr_out_if.source                    out_ch
);
  import cfpr_pkg::*;

  logic            in_fire;
  logic            rep_valid;
  reply_t          rep;
  logic            pend_valid_q;
  reply_t          pend_q;
  logic            act_valid_q;
  reply_t          act_q;
  logic [CntW-1:0] cnt_q;
  logic            out_fire;
  logic            act_done;
  logic            load_act;

  cfpr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_fire_i  (in_fire),
    .kind_i       (in_ch.kind),
    .rx_byte_i    (in_ch.rx_byte),
    .busy_req_i   (in_ch.busy_req),
    .reply_valid_o(rep_valid),
    .reply_o      (rep)
  );

  assign out_fire    = act_valid_q && out_ch.ready;
  assign act_done    = out_fire && (cnt_q == LastIdx);
  assign load_act    = pend_valid_q && (!act_valid_q || act_done);
  assign in_ch.ready = !pend_valid_q || load_act;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (rep_valid) begin
      pend_valid_q <= 1'b1;
    end else if (load_act) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_valid) begin
      pend_q <= rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (load_act) begin
      act_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (act_done) begin
      act_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (out_fire) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_act) begin
      act_q <= pend_q;
    end
  end

  assign out_ch.valid      = act_valid_q;
  assign out_ch.tx_byte    = act_q.bytes[cnt_q];
  assign out_ch.last_byte  = (cnt_q == LastIdx);
  assign out_ch.msg_type   = act_q.msg_type;
  assign out_ch.data_byte  = act_q.data_byte;
  assign out_ch.refused    = act_q.refused;
  assign out_ch.from_frame = act_q.from_frame;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_valid_q |-> (cnt_q <= LastIdx))
    else $error("reply byte counter beyond the last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_valid_q |-> in_ch.ready)
    else $error("input stalled with the pending reply register free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !load_act) |=> pend_valid_q)
    else $error("pending reply lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_valid && pend_valid_q) |-> load_act)
    else $error("new reply overwrote a pending reply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_valid_q && !out_ch.ready) |=> (act_valid_q && $stable(cnt_q)))
    else $error("reply position moved while the receiver stalled");

endmodule

@@ src/cfpr_parser.sv @@
// ----------------------------------------------------------------------------
// Command frame parser
// Holds the command codes and the frame position, checks each frame and
// builds the reply for a good frame or a completed-frame request.
// ----------------------------------------------------------------------------
module cfpr_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cfpr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cfpr_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             item_fire_i,
  input  logic                             kind_i,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             busy_req_i,
  output logic                             reply_valid_o,
  output cfpr_pkg::reply_t                 reply_o
);
  import cfpr_pkg::*;

  logic [7:0] start_code_q, stop_code_q, pause_code_q, raise_code_q, lower_code_q;
  logic [7:0] nak_value_q;
  frame_pos_e pos_q, pos_d;
  logic [7:0] cmd_q, cmd_d, data_q, data_d, chk_q, chk_d;
  msg_type_e  msg_type;
  logic       refuse;
  logic       frame_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= 8'd1;
      stop_code_q  <= 8'd2;
      pause_code_q <= 8'd3;
      raise_code_q <= 8'd4;
      lower_code_q <= 8'd5;
      nak_value_q  <= 8'd21;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_CODE: start_code_q <= cfg_wdata_i;
        CFG_STOP_CODE:  stop_code_q  <= cfg_wdata_i;
        CFG_PAUSE_CODE: pause_code_q <= cfg_wdata_i;
        CFG_RAISE_CODE: raise_code_q <= cfg_wdata_i;
        CFG_LOWER_CODE: lower_code_q <= cfg_wdata_i;
        CFG_NAK_VALUE:  nak_value_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    data_d   = data_q;
    chk_d    = chk_q;
    frame_ok = 1'b0;
    if (item_fire_i && !kind_i) begin
      case (pos_q)
        POS_HUNT: if (rx_byte_i == SofByte) pos_d = POS_CMD;
        POS_CMD: begin
          cmd_d = rx_byte_i;
          pos_d = POS_DATA;
        end
        POS_DATA: begin
          data_d = rx_byte_i;
          pos_d  = POS_CHK;
        end
        POS_CHK: begin
          chk_d = rx_byte_i;
          pos_d = POS_END;
        end
        POS_END: begin
          pos_d    = POS_HUNT;
          frame_ok = (rx_byte_i == EofByte) && (chk_q == 8'(cmd_q + data_q));
        end
        default: pos_d = POS_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HUNT;
      cmd_q  <= 8'd0;
      data_q <= 8'd0;
      chk_q  <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      cmd_q  <= cmd_d;
      data_q <= data_d;
      chk_q  <= chk_d;
    end
  end

  // The first matching code wins when several registers hold the same value.
  always_comb begin
    if (cmd_q == start_code_q)      msg_type = MSG_GO;
    else if (cmd_q == stop_code_q)  msg_type = MSG_HALT;
    else if (cmd_q == pause_code_q) msg_type = MSG_HOLD;
    else if (cmd_q == raise_code_q) msg_type = MSG_RAISE;
    else if (cmd_q == lower_code_q) msg_type = MSG_LOWER;
    else                            msg_type = MSG_NONE;
  end

  assign refuse = (cmd_q == start_code_q) && busy_req_i;

  always_comb begin
    reply_valid_o = 1'b0;
    reply_o       = '0;
    if (item_fire_i && kind_i) begin
      reply_valid_o = 1'b1;
      reply_o.bytes = {EofByte, 8'(DoneCmd + DoneData), DoneData, DoneCmd, SofByte};
      reply_o.msg_type = MSG_NONE;
    end else if (frame_ok) begin
      reply_valid_o      = 1'b1;
      reply_o.msg_type   = msg_type;
      reply_o.data_byte  = data_q;
      reply_o.refused    = refuse;
      reply_o.from_frame = 1'b1;
      if (refuse) begin
        reply_o.bytes = {ReplyLen{nak_value_q}};
      end else begin
        reply_o.bytes = {EofByte, chk_q, data_q, cmd_q, SofByte};
      end
    end
  end

endmodule

@@ verif/command_frame_parser_responder_unit_test.sv @@
// ----------------------------------------------------------------------------
// Command frame parser and responder testbench
// Drives byte items and completed-frame requests into the unit with random
// gaps and stalls. A scoreboard predicts every reply item from its own copy of
// the parser state and command registers, and checks each reply field by field.
// ----------------------------------------------------------------------------
module command_frame_parser_responder_unit_test;
  import cfpr_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned LongHoldOff   = 80;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    msg_type_e  msg_type;
    logic [7:0] data_byte;
    logic       refused;
    logic       from_frame;
  } reply_byte_t;

  class reply_scoreboard;
    logic [7:0]    start_code, stop_code, pause_code, raise_code, lower_code, nak_byte;
    frame_pos_e    position;
    logic [7:0]    cmd_held, data_held, chk_held;
    reply_byte_t   expected_q[$];
    int unsigned   mismatches;

    function new();
      start_code = 8'd1;
      stop_code  = 8'd2;
      pause_code = 8'd3;
      raise_code = 8'd4;
      lower_code = 8'd5;
      nak_byte   = 8'd21;
      position   = POS_HUNT;
      cmd_held   = '0;
      data_held  = '0;
      chk_held   = '0;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_START_CODE: start_code = value;
        CFG_STOP_CODE:  stop_code  = value;
        CFG_PAUSE_CODE: pause_code = value;
        CFG_RAISE_CODE: raise_code = value;
        CFG_LOWER_CODE: lower_code = value;
        CFG_NAK_VALUE:  nak_byte   = value;
        default: ;
      endcase
    endfunction

    function msg_type_e classify(logic [7:0] cmd);
      if (cmd == start_code) return MSG_GO;
      if (cmd == stop_code)  return MSG_HALT;
      if (cmd == pause_code) return MSG_HOLD;
      if (cmd == raise_code) return MSG_RAISE;
      if (cmd == lower_code) return MSG_LOWER;
      return MSG_NONE;
    endfunction

    function void push_reply(logic [0:ReplyLen-1][7:0] bytes, msg_type_e mt,
                             logic [7:0] data, logic refused, logic from_frame);
      reply_byte_t r;
      for (int k = 0; k < ReplyLen; k++) begin
        r.tx_byte    = bytes[k];
        r.last_byte  = (k == ReplyLen - 1);
        r.msg_type   = mt;
        r.data_byte  = data;
        r.refused    = refused;
        r.from_frame = from_frame;
        expected_q.push_back(r);
      end
    endfunction

    function void take_rx_item(logic kind, logic [7:0] rx, logic busy);
      logic refuse;
      if (kind) begin
        push_reply({SofByte, DoneCmd, DoneData, 8'(DoneCmd + DoneData), EofByte},
                   MSG_NONE, 8'h00, 1'b0, 1'b0);
        return;
      end
      case (position)
        POS_HUNT: if (rx == SofByte) position = POS_CMD;
        POS_CMD: begin
          cmd_held = rx;
          position = POS_DATA;
        end
        POS_DATA: begin
          data_held = rx;
          position  = POS_CHK;
        end
        POS_CHK: begin
          chk_held = rx;
          position = POS_END;
        end
        default: begin
          position = POS_HUNT;
          if (rx == EofByte && chk_held == 8'(cmd_held + data_held)) begin
            refuse = (cmd_held == start_code) && busy;
            if (refuse) begin
              push_reply({ReplyLen{nak_byte}}, classify(cmd_held), data_held, 1'b1, 1'b1);
            end else begin
              push_reply({SofByte, cmd_held, data_held, chk_held, EofByte},
                         classify(cmd_held), data_held, 1'b0, 1'b1);
            end
          end
        end
      endcase
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply_item(logic [7:0] tx, logic last, logic [2:0] mt,
                                   logic [7:0] data, logic refused, logic from_frame);
      reply_byte_t want;
      if (expected_q.size() == 0) begin
        $error("Reply item with nothing expected: tx_byte %0h", tx);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare("tx_byte", want.tx_byte, tx);
      compare("last_byte", 8'(want.last_byte), 8'(last));
      compare("msg_type", 8'(want.msg_type), 8'(mt));
      compare("data_byte", want.data_byte, data);
      compare("refused", 8'(want.refused), 8'(refused));
      compare("from_frame", 8'(want.from_frame), 8'(from_frame));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  cfpr_in_if  in_ch ();
  cfpr_out_if out_ch ();

  reply_scoreboard replies = new();
  bit              steady;
  int unsigned     hold_request;
  int unsigned     idle_cycles;
  int unsigned     items_sent;

  command_frame_parser_responder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [7:0] rx, logic busy);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.rx_byte  <= rx;
    in_ch.busy_req <= busy;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    replies.take_rx_item(kind, rx, busy);
    items_sent++;
  endtask

  task automatic send_frame_bytes(logic [0:ReplyLen-1][7:0] b, logic busy_last);
    for (int k = 0; k < ReplyLen; k++) begin
      send_item(1'b0, b[k], (k == ReplyLen - 1) ? busy_last : !busy_last);
    end
  endtask

  task automatic send_frame();
    logic [7:0]  cmd, data, chk, tail;
    int unsigned done_at;
    logic [0:ReplyLen-1][7:0] b;
    case ($urandom_range(0, 9))
      0: cmd = replies.start_code;
      1: cmd = replies.stop_code;
      2: cmd = replies.pause_code;
      3: cmd = replies.raise_code;
      4: cmd = replies.lower_code;
      5: cmd = replies.start_code;
      6: cmd = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
      default: cmd = 8'($urandom);
    endcase
    data = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                       : 8'($urandom);
    chk = 8'(cmd + data);
    if ($urandom_range(0, 9) == 0) chk = 8'(chk + $urandom_range(1, 255));
    tail = EofByte;
    if ($urandom_range(0, 9) == 0) tail = EofByte ^ 8'($urandom_range(1, 255));
    b = {SofByte, cmd, data, chk, tail};
    done_at = $urandom_range(0, 24);
    for (int k = 0; k < ReplyLen; k++) begin
      if (k == done_at) send_item(1'b1, 8'($urandom), 1'($urandom));
      send_item(1'b0, b[k], 1'($urandom));
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3)) begin
      send_item(($urandom_range(0, 3) == 0), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_frame();
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (replies.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    replies.set_register(idx, value);
  endtask

  task automatic write_setting(logic [7:0] st, logic [7:0] sp, logic [7:0] pa,
                               logic [7:0] ra, logic [7:0] lo, logic [7:0] nak);
    write_register(CFG_START_CODE, st);
    write_register(CFG_STOP_CODE, sp);
    write_register(CFG_PAUSE_CODE, pa);
    write_register(CFG_RAISE_CODE, ra);
    write_register(CFG_LOWER_CODE, lo);
    write_register(CFG_NAK_VALUE, nak);
  endtask

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 3);
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      replies.check_reply_item(out_ch.tx_byte, out_ch.last_byte, out_ch.msg_type,
                               out_ch.data_byte, out_ch.refused, out_ch.from_frame);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_START_CODE;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = 1'b0;
    in_ch.rx_byte  = '0;
    in_ch.busy_req = 1'b0;
    steady         = 1'b0;
    hold_request   = 0;
    idle_cycles    = 0;
    items_sent     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset values of the registers.
    send_item(1'b0, 8'h00, 1'b1);
    send_frame_bytes({SofByte, 8'h01, 8'hFF, 8'h00, EofByte}, 1'b1);
    send_item(1'b0, SofByte, 1'b1);
    send_item(1'b0, 8'h01, 1'b1);
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b0, 8'h01, 1'b1);
    send_item(1'b0, EofByte, 1'b0);
    send_frame_bytes({SofByte, 8'h05, 8'h80, 8'h85, 8'h00}, 1'b0);
    send_frame_bytes({SofByte, 8'hFF, 8'h01, 8'h01, EofByte}, 1'b0);
    send_frame_bytes({SofByte, 8'h09, 8'hFF, 8'h08, EofByte}, 1'b1);
    send_item(1'b0, 8'hFF, 1'b0);
    wait_idle();

    write_setting(8'h00, 8'hFF, SofByte, EofByte, DoneCmd, 8'hFF);
    run_random(90);
    wait_idle();

    write_setting(8'h40, 8'h40, 8'h41, 8'h41, 8'h40, 8'h00);
    steady = 1'b1;
    run_random(80);
    wait_idle();
    steady = 1'b0;

    write_setting(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd21);
    hold_request = LongHoldOff;
    run_random(90);
    wait_idle();

    write_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    run_random(80);
    wait_idle();

    if (replies.mismatches == 0 && replies.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
